// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the vertex transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, muted while reset is asserted.
`define HVT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
// Checked property, evaluated during reset as well.
`define HVT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define HVT_ASSERT(lbl, clk, rstn, prop)
`define HVT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/hvt_pkg.sv =====
// Types and constants shared by the vertex transform modules.
package hvt_pkg;

  localparam int unsigned COMP_W    = 32;
  localparam int unsigned NUM_ROWS  = 4;
  localparam int unsigned NUM_COLS  = 4;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_SEL_W = 3;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned PROD_W    = 2 * COMP_W;
  localparam int unsigned PAIR_W    = PROD_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 2;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [REG_W-1:0]         mat_reg_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // One vertex, components in row order.
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } vtx_t;

  typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][COMP_W-1:0] coef_mat_t;
  typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][PROD_W-1:0] prod_arr_t;
  typedef logic [NUM_ROWS-1:0][1:0][PAIR_W-1:0]          pair_arr_t;
  typedef logic [NUM_ROWS-1:0][SUM_W-1:0]                sum_arr_t;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic mul;
    logic pair;
    logic sum;
    logic outp;
  } pipe_en_t;

  // Matrix register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 4'd0,
    REG_ROW0_COLS23 = 4'd1,
    REG_ROW1_COLS01 = 4'd2,
    REG_ROW1_COLS23 = 4'd3,
    REG_ROW2_COLS01 = 4'd4,
    REG_ROW2_COLS23 = 4'd5,
    REG_ROW3_COLS01 = 4'd6,
    REG_ROW3_COLS23 = 4'd7
  } reg_idx_t;

endpackage

// ===== rtl/hvt_if.sv =====
// Stream and configuration interfaces of the vertex transform.
interface hvt_vtx_if;
  import hvt_pkg::*;
  logic  valid;
  logic  ready;
  comp_t in_x;
  comp_t in_y;
  comp_t in_z;
  comp_t in_w;
  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface hvt_res_if;
  import hvt_pkg::*;
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;
  logic  saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

interface hvt_cfg_if;
  import hvt_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  mat_reg_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/hvt_coef_regs.sv =====
// Matrix coefficient registers, written through the configuration port.
module hvt_coef_regs #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  hvt_pkg::cfg_idx_t   cfg_index,
  input  hvt_pkg::mat_reg_t   cfg_data,
  output hvt_pkg::coef_mat_t  coef
);
  import hvt_pkg::*;

  localparam mat_reg_t ONE_LO = mat_reg_t'(1) << FRAC_BITS;
  localparam mat_reg_t ONE_HI = ONE_LO << COMP_W;

  mat_reg_t mat_r [NUM_REGS];

  // Reset to the identity; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_SEL_W'(REG_ROW0_COLS01)] <= ONE_LO;
      mat_r[REG_SEL_W'(REG_ROW0_COLS23)] <= '0;
      mat_r[REG_SEL_W'(REG_ROW1_COLS01)] <= ONE_HI;
      mat_r[REG_SEL_W'(REG_ROW1_COLS23)] <= '0;
      mat_r[REG_SEL_W'(REG_ROW2_COLS01)] <= '0;
      mat_r[REG_SEL_W'(REG_ROW2_COLS23)] <= ONE_LO;
      mat_r[REG_SEL_W'(REG_ROW3_COLS01)] <= '0;
      mat_r[REG_SEL_W'(REG_ROW3_COLS23)] <= ONE_HI;
    end else if (cfg_we && (cfg_index < cfg_idx_t'(NUM_REGS))) begin
      mat_r[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Even columns sit in the low half of a register, odd columns in the high half.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if ((c % 2) == 0) begin
          coef[r][c] = mat_r[REG_SEL_W'(2 * r + c / 2)][COMP_W-1:0];
        end else begin
          coef[r][c] = mat_r[REG_SEL_W'(2 * r + c / 2)][REG_W-1:COMP_W];
        end
      end
    end
  end

endmodule

// ===== rtl/hvt_mul_stage.sv =====
// First pipeline stage: sixteen signed 32x32 coefficient products.
module hvt_mul_stage (
  input  logic                clk,
  input  hvt_pkg::pipe_en_t   en,
  input  hvt_pkg::vtx_t       vtx,
  input  hvt_pkg::coef_mat_t  coef,
  output hvt_pkg::prod_arr_t  prod_r
);
  import hvt_pkg::*;

  comp_t     comp [NUM_COLS];
  prod_arr_t prod_nxt;

  always_comb begin
    comp[0] = vtx.x;
    comp[1] = vtx.y;
    comp[2] = vtx.z;
    comp[3] = vtx.w;
  end

  // Each product is exact in 64 bits.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod_nxt[r][c] = PROD_W'($signed(coef[r][c])) * PROD_W'(comp[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/hvt_sum_stage.sv =====
// Second and third pipeline stages: a two-level registered adder tree per row.
module hvt_sum_stage (
  input  logic                clk,
  input  hvt_pkg::pipe_en_t   en,
  input  hvt_pkg::prod_arr_t  prod,
  output hvt_pkg::sum_arr_t   sum_r
);
  import hvt_pkg::*;

  pair_arr_t pair_r;
  pair_arr_t pair_nxt;
  sum_arr_t  sum_nxt;

  // Columns 0+1 and 2+3 of each row, one bit of growth.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < 2; k++) begin
        pair_nxt[r][k] = PAIR_W'($signed(prod[r][2 * k])) +
                         PAIR_W'($signed(prod[r][2 * k + 1]));
      end
    end
  end

  // Full-precision row sum.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_nxt[r] = SUM_W'($signed(pair_r[r][0])) + SUM_W'($signed(pair_r[r][1]));
    end
  end

  always_ff @(posedge clk) begin
    if (en.pair) begin
      pair_r <= pair_nxt;
    end
    if (en.sum) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== rtl/hvt_sat_stage.sv =====
// Last pipeline stage: arithmetic shift, saturation to 32 bits, output register.
module hvt_sat_stage #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  hvt_pkg::pipe_en_t  en,
  input  hvt_pkg::sum_arr_t  sum,
  output hvt_pkg::vtx_t      res_r,
  output logic               sat_r
);
  import hvt_pkg::*;

  logic signed [SUM_W-1:0] shifted [NUM_ROWS];
  comp_t                   comp    [NUM_ROWS];
  logic [NUM_ROWS-1:0]     clip;
  vtx_t                    res_nxt;
  logic                    sat_nxt;

  // The shift floors; a row clips when its upper bits are not all sign copies.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      shifted[r] = $signed(sum[r]) >>> FRAC_BITS;
      clip[r]    = !((&shifted[r][SUM_W-1:COMP_W-1]) || !(|shifted[r][SUM_W-1:COMP_W-1]));
      if (clip[r]) begin
        comp[r] = {shifted[r][SUM_W-1], {(COMP_W-1){~shifted[r][SUM_W-1]}}};
      end else begin
        comp[r] = shifted[r][COMP_W-1:0];
      end
    end
    res_nxt.x = comp[0];
    res_nxt.y = comp[1];
    res_nxt.z = comp[2];
    res_nxt.w = comp[3];
    sat_nxt   = |clip;
  end

  always_ff @(posedge clk) begin
    if (en.outp) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

// ===== rtl/homogeneous_vertex_transform_top.sv =====
// Top level of the homogeneous vertex transform: 4x4 matrix times vertex.
// Each accepted vertex word (x, y, z, w in signed fixed point) is multiplied by
// the 4x4 matrix held in eight 64-bit registers; the result word passes through
// one stage of sixteen parallel 32x32 multipliers, two stages of adder tree and
// one stage of shift, saturation and output register. A new vertex is taken
// every cycle while the result side keeps up; a stall holds full stages and
// fills empty ones before input ready drops. The saturated flag is set when any
// component was clamped to 32 bits. The matrix resets to the identity; the user
// must write it only while the pipeline is empty; the block does not check it.
`include "assert_macros.svh"
module homogeneous_vertex_transform_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  hvt_vtx_if.sink   in_vtx,
  hvt_res_if.source out_res,
  hvt_cfg_if.sink   cfg_wr
);
  import hvt_pkg::*;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  logic      v_mul_r, v_pair_r, v_sum_r, v_out_r;
  logic      v_mul_nxt, v_pair_nxt, v_sum_nxt, v_out_nxt;
  logic      rdy_mul, rdy_pair, rdy_sum, rdy_out;
  pipe_en_t  en;
  vtx_t      vtx;
  coef_mat_t coef;
  prod_arr_t prod;
  sum_arr_t  sum;
  vtx_t      res;
  logic      sat;
  logic      any_rail;
  logic      pipe_full;

  // The matrix registers accept a write in every cycle.
  assign cfg_wr.ready = 1'b1;

  hvt_coef_regs #(.FRAC_BITS(FRAC_BITS)) u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr.valid && cfg_wr.ready),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .coef      (coef)
  );

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    rdy_out  = !v_out_r  || out_res.ready;
    rdy_sum  = !v_sum_r  || rdy_out;
    rdy_pair = !v_pair_r || rdy_sum;
    rdy_mul  = !v_mul_r  || rdy_pair;
    en.mul   = rdy_mul;
    en.pair  = rdy_pair;
    en.sum   = rdy_sum;
    en.outp  = rdy_out;
  end

  always_comb begin
    v_mul_nxt  = rdy_mul  ? in_vtx.valid : v_mul_r;
    v_pair_nxt = rdy_pair ? v_mul_r      : v_pair_r;
    v_sum_nxt  = rdy_sum  ? v_pair_r     : v_sum_r;
    v_out_nxt  = rdy_out  ? v_sum_r      : v_out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r  <= 1'b0;
      v_pair_r <= 1'b0;
      v_sum_r  <= 1'b0;
      v_out_r  <= 1'b0;
    end else begin
      v_mul_r  <= v_mul_nxt;
      v_pair_r <= v_pair_nxt;
      v_sum_r  <= v_sum_nxt;
      v_out_r  <= v_out_nxt;
    end
  end

  assign in_vtx.ready = rdy_mul;

  always_comb begin
    vtx.x = in_vtx.in_x;
    vtx.y = in_vtx.in_y;
    vtx.z = in_vtx.in_z;
    vtx.w = in_vtx.in_w;
  end

  hvt_mul_stage u_mul_stage (
    .clk    (clk),
    .en     (en),
    .vtx    (vtx),
    .coef   (coef),
    .prod_r (prod)
  );

  hvt_sum_stage u_sum_stage (
    .clk   (clk),
    .en    (en),
    .prod  (prod),
    .sum_r (sum)
  );

  hvt_sat_stage #(.FRAC_BITS(FRAC_BITS)) u_sat_stage (
    .clk   (clk),
    .en    (en),
    .sum   (sum),
    .res_r (res),
    .sat_r (sat)
  );

  // Result word.
  assign out_res.valid     = v_out_r;
  assign out_res.out_x     = res.x;
  assign out_res.out_y     = res.y;
  assign out_res.out_z     = res.z;
  assign out_res.out_w     = res.w;
  assign out_res.saturated = sat;

  // True when some output component sits on a rail of the 32-bit range.
  assign any_rail = (res.x == COMP_MAX) || (res.x == COMP_MIN) ||
                    (res.y == COMP_MAX) || (res.y == COMP_MIN) ||
                    (res.z == COMP_MAX) || (res.z == COMP_MIN) ||
                    (res.w == COMP_MAX) || (res.w == COMP_MIN);

  // Every pipeline stage holds a word.
  assign pipe_full = v_mul_r && v_pair_r && v_sum_r && v_out_r;

  // Input ready drops only when every stage is full and the output is stalled.
  `HVT_ASSERT(a_ready_full, clk, rst_n, !in_vtx.ready |-> (pipe_full && !out_res.ready))
  // A word held in the last adder stage is never dropped.
  `HVT_ASSERT(a_sum_hold, clk, rst_n, (v_sum_r && !rdy_sum) |=> v_sum_r)
  // A saturated result always carries a clamped component.
  `HVT_ASSERT(a_sat_rail, clk, rst_n, (out_res.valid && out_res.saturated) |-> any_rail)
  // No result is offered in the cycle after a reset edge.
  `HVT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_res.valid)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the homogeneous vertex transform top level.
`timescale 1ns / 100ps
module testbench;
  import hvt_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned PIPE_LAT     = 4;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam comp_t       COMP_MAX     = 32'sh7FFF_FFFF;
  localparam comp_t       COMP_MIN     = 32'sh8000_0000;
  localparam comp_t       ONE          = 32'sd1 <<< FRAC_BITS;
  localparam longint      SAT_HI       = 64'sd2147483647;
  localparam longint      SAT_LO       = -64'sd2147483648;
  localparam cfg_idx_t    BAD_IDX_LO   = cfg_idx_t'(NUM_REGS);
  localparam cfg_idx_t    BAD_IDX_HI   = '1;

  // Whole matrix, one 64-bit register per entry.
  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  // Transformed vertex as the block reports it.
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
    logic  sat;
  } xform_t;

  // Kinds of matrix used by the random phases.
  typedef enum int {
    MAT_IDENTITY,
    MAT_FULL_RANDOM,
    MAT_SMALL,
    MAT_ALL_MAX,
    MAT_ALL_MIN,
    MAT_ZERO,
    MAT_EXTREME_MIX
  } mat_kind_t;

  logic clk;
  logic rst_n;

  hvt_vtx_if vtx_ch ();
  hvt_res_if res_ch ();
  hvt_cfg_if cfg_ch ();

  homogeneous_vertex_transform_top #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (vtx_ch),
    .out_res(res_ch),
    .cfg_wr (cfg_ch)
  );

  matrix_t     matrix_model;
  xform_t      pending_results[$];
  bit          rx_stalls;
  bit          tx_gaps;
  int unsigned vertices_sent;
  int unsigned results_checked;
  int unsigned saturated_seen;
  int unsigned cfg_writes;
  int unsigned ignored_writes;
  int unsigned matrix_settings;
  int unsigned mismatches;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Packs two coefficients of one row into a register word.
  function automatic mat_reg_t coef_pair(comp_t even_c, comp_t odd_c);
    return {odd_c, even_c};
  endfunction

  function automatic matrix_t identity_matrix();
    matrix_t m;
    m = '0;
    m[REG_ROW0_COLS01] = coef_pair(ONE, '0);
    m[REG_ROW1_COLS01] = coef_pair('0, ONE);
    m[REG_ROW2_COLS23] = coef_pair(ONE, '0);
    m[REG_ROW3_COLS23] = coef_pair('0, ONE);
    return m;
  endfunction

  // Exact dot product per row, floor shift, then clamp to 32 bits.
  function automatic xform_t transform_vertex(vtx_t v);
    logic signed [SUM_W+1:0] acc;
    logic signed [SUM_W+1:0] coef_ext;
    logic signed [SUM_W+1:0] comp_ext;
    comp_t    comps[NUM_COLS];
    comp_t    rows_out[NUM_ROWS];
    mat_reg_t row_reg;
    comp_t    coef;
    xform_t   r;
    comps = '{v.x, v.y, v.z, v.w};
    r.sat = 1'b0;
    for (int row = 0; row < NUM_ROWS; row++) begin
      acc = '0;
      for (int col = 0; col < NUM_COLS; col++) begin
        row_reg  = matrix_model[2 * row + col / 2];
        coef     = (col % 2) ? row_reg[63:32] : row_reg[31:0];
        coef_ext = coef;
        comp_ext = comps[col];
        acc      = acc + coef_ext * comp_ext;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_HI) begin
        rows_out[row] = COMP_MAX;
        r.sat = 1'b1;
      end else if (acc < SAT_LO) begin
        rows_out[row] = COMP_MIN;
        r.sat = 1'b1;
      end else begin
        rows_out[row] = acc[COMP_W-1:0];
      end
    end
    r.x = rows_out[0];
    r.y = rows_out[1];
    r.z = rows_out[2];
    r.w = rows_out[3];
    return r;
  endfunction

  function automatic comp_t extreme_comp();
    case ($urandom_range(0, 6))
      0:       return COMP_MAX;
      1:       return COMP_MIN;
      2:       return '0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      5:       return ONE;
      default: return -ONE;
    endcase
  endfunction

  // Mix of full-range, small Q16.16 and corner values.
  function automatic comp_t random_comp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return comp_t'($urandom);
    if (pick < 85) return comp_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    return extreme_comp();
  endfunction

  function automatic vtx_t random_vertex();
    vtx_t v;
    v.x = random_comp();
    v.y = random_comp();
    v.z = random_comp();
    v.w = random_comp();
    return v;
  endfunction

  function automatic comp_t coef_of_kind(mat_kind_t kind);
    case (kind)
      MAT_FULL_RANDOM: return comp_t'($urandom);
      MAT_SMALL:       return comp_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      MAT_ALL_MAX:     return COMP_MAX;
      MAT_ALL_MIN:     return COMP_MIN;
      MAT_ZERO:        return '0;
      default:         return extreme_comp();
    endcase
  endfunction

  function automatic matrix_t make_matrix(mat_kind_t kind);
    matrix_t m;
    if (kind == MAT_IDENTITY) return identity_matrix();
    for (int i = 0; i < NUM_REGS; i++) m[i] = coef_pair(coef_of_kind(kind), coef_of_kind(kind));
    return m;
  endfunction

  // Offers one config word and holds it until taken; the caller releases valid.
  task automatic write_reg(input cfg_idx_t idx, input mat_reg_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_writes++;
    if (idx < NUM_REGS) matrix_model[idx] = data;
    else ignored_writes++;
  endtask

  task automatic load_matrix(input matrix_t m);
    for (int i = 0; i < NUM_REGS; i++) write_reg(cfg_idx_t'(i), m[i]);
    cfg_ch.valid <= 1'b0;
    matrix_settings++;
  endtask

  // Writes to indexes past the matrix must leave it untouched.
  task automatic write_unused_regs();
    write_reg(BAD_IDX_LO, {$urandom, $urandom});
    write_reg(BAD_IDX_HI, {$urandom, $urandom});
    write_reg(cfg_idx_t'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  // Presents one vertex word and records its expected result once accepted.
  task automatic send_vertex(input vtx_t v);
    vtx_ch.valid <= 1'b1;
    vtx_ch.in_x  <= v.x;
    vtx_ch.in_y  <= v.y;
    vtx_ch.in_z  <= v.z;
    vtx_ch.in_w  <= v.w;
    do @(posedge clk); while (!vtx_ch.ready);
    pending_results.push_back(transform_vertex(v));
    vertices_sent++;
  endtask

  task automatic send_comps(input comp_t x, input comp_t y, input comp_t z, input comp_t w);
    vtx_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.w = w;
    send_vertex(v);
  endtask

  task automatic pause_input(input int unsigned cycles);
    vtx_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops the input and waits until the pipeline has emptied.
  task automatic drain();
    vtx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic stream_random(input int unsigned count);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_vertex(random_vertex());
        sent++;
      end
      if (tx_gaps && $urandom_range(0, 3) != 0) pause_input($urandom_range(1, 6));
    end
  endtask

  // Reset matrix is the identity: every component passes through unclamped.
  task automatic test_reset_identity();
    send_comps('0, '0, '0, '0);
    send_comps(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
    send_comps(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
    send_comps(COMP_MAX, COMP_MIN, -32'sd1, 32'sd1);
    send_comps(ONE, -ONE, 32'sh5555_5555, 32'shAAAA_AAAA);
    drain();
  endtask

  // Floor rounding of negative sums and the exact edges of the 32-bit range.
  task automatic test_negative_truncation();
    matrix_t m;
    m = '0;
    m[REG_ROW0_COLS01] = coef_pair(32'sd1, '0);
    m[REG_ROW1_COLS01] = coef_pair('0, 32'sd2 <<< FRAC_BITS);
    m[REG_ROW2_COLS23] = coef_pair(-32'sd1, '0);
    m[REG_ROW3_COLS23] = coef_pair('0, ONE >>> 1);
    load_matrix(m);
    send_comps(-32'sd1, 32'sh3FFF_FFFF, 32'sd1, 32'sd3);
    send_comps(32'sd1, -32'sh4000_0000, -32'sd1, -32'sd3);
    send_comps(-32'sd65537, 32'sh4000_0000, 32'sd65535, -32'sd1);
    send_comps(32'sd65535, -32'sh4000_0001, COMP_MIN, COMP_MIN);
    // Unused indexes written here must not disturb this matrix.
    drain();
    write_unused_regs();
    send_comps(-32'sd1, 32'sd7, 32'sd1, 32'sd3);
    drain();
  endtask

  // Clamping in both directions, including the largest possible sum.
  task automatic test_saturation();
    load_matrix(make_matrix(MAT_ALL_MAX));
    send_comps(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
    send_comps(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
    send_comps(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN);
    drain();
    load_matrix(make_matrix(MAT_ALL_MIN));
    send_comps(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
    send_comps(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
    send_comps(32'sd1, -32'sd1, '0, ONE);
    drain();
    load_matrix(identity_matrix());
    write_reg(REG_ROW0_COLS01, coef_pair(ONE <<< 1, '0));
    write_reg(REG_ROW3_COLS23, coef_pair('0, -(ONE <<< 1)));
    cfg_ch.valid <= 1'b0;
    send_comps(32'sh4000_0000, COMP_MAX, COMP_MIN, 32'sh4000_0000);
    send_comps(32'sh3FFF_FFFF, '0, '0, COMP_MIN);
    drain();
  endtask

  // Long random streams, each under a different matrix kind; some phases turn off result stalls or input gaps.
  task automatic test_random_streams();
    mat_kind_t kinds[7];
    kinds = '{MAT_FULL_RANDOM, MAT_SMALL, MAT_IDENTITY, MAT_ALL_MAX,
              MAT_EXTREME_MIX, MAT_ZERO, MAT_ALL_MIN};
    for (int p = 0; p < 7; p++) begin
      rx_stalls = (p != 1);
      tx_gaps   = (p != 1) && (p != 4);
      load_matrix(make_matrix(kinds[p]));
      if (p % 3 == 0) write_unused_regs();
      stream_random(PHASE_ITEMS);
      drain();
    end
    rx_stalls = 1'b1;
    tx_gaps   = 1'b1;
  endtask

  // Result side: compare each accepted word, then drive the stall pattern.
  initial begin : result_checker
    xform_t      exp_res;
    int unsigned run_left;
    logic        run_level;
    run_left  = 0;
    run_level = 1'b1;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("unexpected result word: x=%0d y=%0d z=%0d w=%0d",
                 res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.out_w);
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          if (exp_res.sat) saturated_seen++;
          if (res_ch.out_x !== exp_res.x) begin
            $error("out_x mismatch: expected %0d, got %0d", exp_res.x, res_ch.out_x);
            mismatches++;
          end
          if (res_ch.out_y !== exp_res.y) begin
            $error("out_y mismatch: expected %0d, got %0d", exp_res.y, res_ch.out_y);
            mismatches++;
          end
          if (res_ch.out_z !== exp_res.z) begin
            $error("out_z mismatch: expected %0d, got %0d", exp_res.z, res_ch.out_z);
            mismatches++;
          end
          if (res_ch.out_w !== exp_res.w) begin
            $error("out_w mismatch: expected %0d, got %0d", exp_res.w, res_ch.out_w);
            mismatches++;
          end
          if (res_ch.saturated !== exp_res.sat) begin
            $error("saturated mismatch: expected %0b, got %0b", exp_res.sat,
                   res_ch.saturated);
            mismatches++;
          end
        end
      end
      // Alternate runs of ready and stall with random lengths.
      if (run_left == 0) begin
        run_level = ~run_level;
        run_left  = run_level ? $urandom_range(1, 16) : $urandom_range(1, 6);
      end
      run_left--;
      res_ch.ready <= rx_stalls ? run_level : 1'b1;
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    vtx_ch.valid <= 1'b0;
    vtx_ch.in_x  <= '0;
    vtx_ch.in_y  <= '0;
    vtx_ch.in_z  <= '0;
    vtx_ch.in_w  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;
    rx_stalls    = 1'b1;
    tx_gaps      = 1'b1;
    matrix_model = identity_matrix();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_identity();
    test_negative_truncation();
    test_saturation();
    test_random_streams();
    drain();

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Checked %0d results for %0d vertices, %0d of them clamped.",
             results_checked, vertices_sent, saturated_seen);
    $display("Loaded %0d matrices with %0d register writes, %0d to unused indexes.",
             matrix_settings, cfg_writes, ignored_writes);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
